// ===== hdl/hecl_pkg.sv =====
package hecl_pkg;

    localparam int ENTITY_WINDOW_DEF = 12;
    localparam int IQ_DEPTH = 2;
    localparam int OQ_DEPTH = 8;
    localparam int BUDGET_W = 17;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 17'd256;
    localparam int CP_W = 21;
    localparam logic [CP_W-1:0] CP_LIMIT = 21'h110000;
    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SPACE = 21'h000020;
    localparam logic [7:0] CH_AMP = 8'h26;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam int NUM_ENT = 23;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_RES,
        ST_EMIT,
        ST_END
    } t_state;

    typedef struct packed {
        logic       amp;
        logic       semi;
        logic       ws;
        logic       hash;
        logic       xch;
        logic       dig_dec;
        logic       dig_hex;
        logic [3:0] dval;
        logic       lead;
        logic [1:0] lrem;
    } t_cls;

    typedef struct packed {
        logic            hit;
        logic [CP_W-1:0] cp;
    } t_ent;

    typedef struct packed {
        logic [2:0] n;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
    } t_utf;

    // Names are right-aligned: the last character sits in the low byte.
    localparam logic [47:0] ENT_NAME [NUM_ENT] = '{
        48'("amp"), 48'("lt"), 48'("gt"), 48'("quot"), 48'("apos"), 48'("nbsp"),
        48'("ndash"), 48'("mdash"), 48'("hellip"), 48'("laquo"), 48'("raquo"),
        48'("copy"), 48'("eacute"), 48'("egrave"), 48'("agrave"), 48'("uuml"),
        48'("ouml"), 48'("auml"), 48'("szlig"), 48'("rsquo"), 48'("lsquo"),
        48'("rdquo"), 48'("ldquo")
    };
    localparam logic [2:0] ENT_LEN [NUM_ENT] = '{
        3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd5, 3'd5,
        3'd4, 3'd6, 3'd6, 3'd6, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
    };
    localparam logic [CP_W-1:0] ENT_CP [NUM_ENT] = '{
        21'h26, 21'h3C, 21'h3E, 21'h22, 21'h27, 21'h20, 21'h2013, 21'h2014,
        21'h2026, 21'hAB, 21'hBB, 21'hA9, 21'hE9, 21'hE8, 21'hE0, 21'hFC,
        21'hF6, 21'hE4, 21'hDF, 21'h2019, 21'h2018, 21'h201D, 21'h201C
    };

    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        r = '0;
        r.amp  = (c == 8'h26);
        r.semi = (c == 8'h3B);
        r.ws   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
        r.hash = (c == 8'h23);
        r.xch  = (c == 8'h78) || (c == 8'h58);
        if (c >= 8'h30 && c <= 8'h39) begin
            r.dig_dec = 1'b1;
            r.dig_hex = 1'b1;
            r.dval    = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.dig_hex = 1'b1;
            r.dval    = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.dig_hex = 1'b1;
            r.dval    = 4'(c - 8'h37);
        end
        if (c[7:5] == 3'b110) begin
            r.lead = 1'b1;
            r.lrem = 2'd1;
        end else if (c[7:4] == 4'b1110) begin
            r.lead = 1'b1;
            r.lrem = 2'd2;
        end else if (c[7:3] == 5'b11110) begin
            r.lead = 1'b1;
            r.lrem = 2'd3;
        end
        return r;
    endfunction

    function automatic t_ent ent_match(input logic [47:0] body, input logic [2:0] elen);
        t_ent r;
        r = '0;
        for (int k = 0; k < NUM_ENT; k++) begin
            if (ENT_LEN[k] == elen && ENT_NAME[k] == body) begin
                r.hit = 1'b1;
                r.cp  = ENT_CP[k];
            end
        end
        return r;
    endfunction

    function automatic t_utf utf8_encode(input logic [CP_W-1:0] cp);
        t_utf r;
        r = '0;
        if (cp < 21'h80) begin
            r.n  = 3'd1;
            r.b0 = cp[7:0];
        end else if (cp < 21'h800) begin
            r.n  = 3'd2;
            r.b0 = {3'b110, cp[10:6]};
            r.b1 = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            r.n  = 3'd3;
            r.b0 = {4'b1110, cp[15:12]};
            r.b1 = {2'b10, cp[11:6]};
            r.b2 = {2'b10, cp[5:0]};
        end else begin
            r.n  = 3'd4;
            r.b0 = {5'b11110, cp[20:18]};
            r.b1 = {2'b10, cp[17:12]};
            r.b2 = {2'b10, cp[11:6]};
            r.b3 = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

// ===== hdl/html_entity_text_cleaner.sv =====
// Channel   Direction  Handshake                   Payload
// input     in         push / full                 i_in_byte, i_last_byte
// result    out        empty / pop                 o_out_byte, o_has_byte, o_end_of_text
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_out_budget
//
// A plain byte is processed in the engine, then its output bytes go out from the emit state.
// A resolved entity also passes through the lookup state; an unresolved one re-feeds its
// buffered bytes, one per cycle while the engine stays in the run state, from the replay queue.
// Reset is synchronous and active low; the budget register returns to 256.
// A full result queue stalls the engine; a stalled engine lets the input queue fill.
module html_entity_text_cleaner #(
    parameter int ENTITY_WINDOW = hecl_pkg::ENTITY_WINDOW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_last_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    o_out_byte,
    output logic                          o_has_byte,
    output logic                          o_end_of_text,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hecl_pkg::BUDGET_W-1:0] i_cfg_out_budget
);

    logic [hecl_pkg::BUDGET_W-1:0] r_budget;
    logic           f_valid, f_last, e_ipop, e_opush, e_has, e_end, oq_full;
    logic [7:0]     f_byte, e_byte;
    hecl_pkg::t_cls f_cls;
    logic [9:0]     oq_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= hecl_pkg::BUDGET_RESET;
        end else if (i_cfg_valid) begin
            r_budget <= i_cfg_out_budget;
        end
    end

    hecl_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_byte (i_in_byte),
        .i_last (i_last_byte),
        .o_full (full),
        .o_valid(f_valid),
        .o_byte (f_byte),
        .o_last (f_last),
        .o_cls  (f_cls),
        .i_pop  (e_ipop)
    );

    hecl_engine #(
        .ENTITY_WINDOW(ENTITY_WINDOW)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_budget(r_budget),
        .i_ivalid(f_valid),
        .i_ibyte (f_byte),
        .i_ilast (f_last),
        .i_icls  (f_cls),
        .o_ipop  (e_ipop),
        .i_ofull (oq_full),
        .o_opush (e_opush),
        .o_obyte (e_byte),
        .o_ohas  (e_has),
        .o_oend  (e_end)
    );

    hecl_fifo #(
        .WIDTH(10),
        .DEPTH(hecl_pkg::OQ_DEPTH)
    ) u_oq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (e_opush),
        .i_data ({e_end, e_has, e_byte}),
        .o_full (oq_full),
        .i_pop  (pop),
        .o_data (oq_head),
        .o_empty(empty)
    );

    assign o_out_byte    = oq_head[7:0];
    assign o_has_byte    = oq_head[8];
    assign o_end_of_text = oq_head[9];

endmodule

// ===== hdl/hecl_fifo.sv =====
module hecl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== hdl/hecl_front.sv =====
module hecl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic          o_full,
    output logic          o_valid,
    output logic [7:0]    o_byte,
    output logic          o_last,
    output hecl_pkg::t_cls o_cls,
    input  logic          i_pop
);

    logic [8:0] head;
    logic       empty;

    hecl_fifo #(
        .WIDTH(9),
        .DEPTH(hecl_pkg::IQ_DEPTH)
    ) u_iq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .i_data ({i_last, i_byte}),
        .o_full (o_full),
        .i_pop  (i_pop),
        .o_data (head),
        .o_empty(empty)
    );

    assign o_valid = !empty;
    assign o_byte  = head[7:0];
    assign o_last  = head[8];
    assign o_cls   = hecl_pkg::classify(head[7:0]);

endmodule

// ===== hdl/hecl_engine.sv =====
module hecl_engine #(
    parameter int ENTITY_WINDOW = hecl_pkg::ENTITY_WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [hecl_pkg::BUDGET_W-1:0]   i_budget,
    input  logic                            i_ivalid,
    input  logic [7:0]                      i_ibyte,
    input  logic                            i_ilast,
    input  hecl_pkg::t_cls                  i_icls,
    output logic                            o_ipop,
    input  logic                            i_ofull,
    output logic                            o_opush,
    output logic [7:0]                      o_obyte,
    output logic                            o_ohas,
    output logic                            o_oend
);

    localparam int W   = ENTITY_WINDOW;
    localparam int LAD = ((W > 7) ? W : 7) + 1;
    localparam int LIW = $clog2(LAD);
    localparam int PIW = $clog2(W);
    localparam int CW  = $clog2(W + 1);
    localparam int BW  = hecl_pkg::BUDGET_W;
    localparam int AW  = hecl_pkg::CP_W;

    hecl_pkg::t_state r_state, n_state;
    logic [7:0]    r_la [LAD];
    logic [7:0]    n_la [LAD];
    logic [CW-1:0] r_la_cnt, n_la_cnt;
    logic [7:0]    r_pend [W];
    logic [7:0]    n_pend [W];
    logic [CW-1:0] r_pcnt, n_pcnt;
    logic          r_after, n_after, r_held, n_held, r_halt, n_halt, r_final, n_final;
    logic [BW-1:0] r_bw, n_bw;
    logic [7:0]    r_seq [3];
    logic [7:0]    n_seq [3];
    logic [1:0]    r_srem, n_srem;
    logic [2:0]    r_slen, n_slen;
    logic          r_hash, n_hash, r_hex, n_hex, r_numok, n_numok, r_ndig, n_ndig;
    logic [AW-1:0] r_acc, n_acc;
    logic [7:0]    r_ob [5];
    logic [7:0]    n_ob [5];
    logic [2:0]    r_on, n_on, r_oi, n_oi;

    logic [7:0]     c;
    hecl_pkg::t_cls cls;
    logic           have, popped, last_in, rep, sp_req, big, em_req;
    logic [7:0]     em_b [4];
    logic [2:0]     em_n, need;
    logic [7:0]     pend_v [W];
    logic [CW-1:0]  pcnt_v, cnt_v;
    logic [24:0]    mul;
    logic [24:0]    acc_sum;
    logic [CW-1:0]  elen;
    logic [47:0]    body;
    hecl_pkg::t_ent ent;
    hecl_pkg::t_utf utf;
    logic [AW-1:0]  cp;
    logic           res_ok;
    int             cv, kk;

    // Next state.
    always_comb begin
        n_state  = r_state;
        n_la     = r_la;
        n_la_cnt = r_la_cnt;
        n_pend   = r_pend;
        n_pcnt   = r_pcnt;
        n_after  = r_after;
        n_held   = r_held;
        n_halt   = r_halt;
        n_final  = r_final;
        n_bw     = r_bw;
        n_seq    = r_seq;
        n_srem   = r_srem;
        n_slen   = r_slen;
        n_hash   = r_hash;
        n_hex    = r_hex;
        n_numok  = r_numok;
        n_ndig   = r_ndig;
        n_acc    = r_acc;
        n_ob     = r_ob;
        n_on     = r_on;
        n_oi     = r_oi;
        o_ipop   = 1'b0;
        have     = 1'b0;
        popped   = 1'b0;
        last_in  = 1'b0;
        rep      = 1'b0;
        sp_req   = 1'b0;
        big      = 1'b0;
        em_req   = 1'b0;
        em_b     = '{default: 8'h00};
        em_n     = 3'd0;
        c        = 8'h00;
        cls      = '0;
        mul      = '0;
        acc_sum  = '0;
        elen     = '0;
        body     = '0;
        ent      = '0;
        utf      = '0;
        cp       = '0;
        res_ok   = 1'b0;
        need     = 3'd0;
        cv       = 0;
        kk       = 0;
        pend_v   = r_pend;
        pcnt_v   = r_pcnt;
        cnt_v    = r_la_cnt;

        unique case (r_state)
            hecl_pkg::ST_RUN: begin
                if (r_pcnt != '0) begin
                    have   = 1'b1;
                    popped = 1'b1;
                    c      = r_pend[0];
                    cls    = hecl_pkg::classify(r_pend[0]);
                end else if (!r_final && i_ivalid) begin
                    have    = 1'b1;
                    o_ipop  = 1'b1;
                    c       = i_ibyte;
                    cls     = i_icls;
                    last_in = i_ilast;
                end else if (r_final) begin
                    if (r_la_cnt != '0 && !r_halt) begin
                        rep = 1'b1;
                    end else begin
                        n_state = hecl_pkg::ST_END;
                    end
                end
                if (popped) begin
                    for (int i = 0; i < W - 1; i++) begin
                        pend_v[i] = r_pend[i+1];
                    end
                    pcnt_v = r_pcnt - 1'b1;
                end
                if (have && !r_halt) begin
                    if (r_srem != 2'd0) begin
                        if (r_srem == 2'd1) begin
                            em_req = 1'b1;
                            em_n   = r_slen;
                            for (int i = 0; i < 3; i++) begin
                                em_b[i] = (3'(i) == r_slen - 3'd1) ? c : r_seq[i];
                            end
                            em_b[3] = c;
                            n_srem  = 2'd0;
                        end else begin
                            n_seq[2'(r_slen - 3'(r_srem))] = c;
                            n_srem = r_srem - 2'd1;
                        end
                    end else if (r_la_cnt != '0) begin
                        n_la[LIW'(r_la_cnt)] = c;
                        cnt_v = r_la_cnt + 1'b1;
                        // Numeric entity digits accumulate as they arrive.
                        if (r_la_cnt == CW'(1)) begin
                            n_hash  = cls.hash;
                            n_hex   = 1'b0;
                            n_numok = 1'b1;
                            n_ndig  = 1'b0;
                            n_acc   = '0;
                        end else if (r_la_cnt == CW'(2) && cls.xch) begin
                            n_hex = 1'b1;
                        end else if (r_hex ? cls.dig_hex : cls.dig_dec) begin
                            mul     = r_hex ? {r_acc, 4'b0000}
                                            : ({4'b0000, r_acc} << 3) + ({4'b0000, r_acc} << 1);
                            acc_sum = mul + 25'(cls.dval);
                            n_acc   = (acc_sum > 25'(hecl_pkg::CP_MAX)) ?
                                      hecl_pkg::CP_LIMIT : acc_sum[AW-1:0];
                            n_ndig  = 1'b1;
                        end else if (!cls.semi) begin
                            n_numok = 1'b0;
                        end
                        if (cls.semi) begin
                            n_state = hecl_pkg::ST_RES;
                        end else if (cnt_v == CW'(W)) begin
                            rep = 1'b1;
                        end
                    end else if (cls.amp) begin
                        n_la[0] = c;
                        cnt_v   = CW'(1);
                    end else if (cls.ws) begin
                        sp_req = 1'b1;
                    end else if (cls.lead) begin
                        n_seq[0] = c;
                        n_srem   = cls.lrem;
                        n_slen   = {1'b0, cls.lrem} + 3'd1;
                    end else begin
                        em_req  = 1'b1;
                        em_n    = 3'd1;
                        em_b[0] = c;
                    end
                end
                if (last_in) begin
                    n_final = 1'b1;
                end
            end
            hecl_pkg::ST_RES: begin
                n_state = hecl_pkg::ST_RUN;
                elen    = r_la_cnt - CW'(2);
                for (int j = 0; j < 6; j++) begin
                    if (CW'(j) < elen) begin
                        body = {body[39:0], r_la[j+1]};
                    end
                end
                if (r_hash && elen > CW'(1)) begin
                    res_ok = r_numok && r_ndig && (r_acc != '0);
                    cp     = r_acc;
                end else begin
                    ent    = hecl_pkg::ent_match(body, 3'(elen));
                    res_ok = ent.hit && (r_la_cnt <= CW'(8));
                    cp     = ent.cp;
                end
                if (res_ok) begin
                    cnt_v = '0;
                    if (cp == hecl_pkg::CP_SPACE) begin
                        sp_req = 1'b1;
                    end else if (cp >= hecl_pkg::CP_LIMIT) begin
                        big = 1'b1;
                    end else begin
                        utf     = hecl_pkg::utf8_encode(cp);
                        em_req  = 1'b1;
                        em_n    = utf.n;
                        em_b[0] = utf.b0;
                        em_b[1] = utf.b1;
                        em_b[2] = utf.b2;
                        em_b[3] = utf.b3;
                    end
                end else begin
                    rep = 1'b1;
                end
            end
            hecl_pkg::ST_EMIT: begin
                if (!i_ofull) begin
                    n_oi = r_oi + 3'd1;
                    if (r_oi == r_on - 3'd1) begin
                        n_state = hecl_pkg::ST_RUN;
                    end
                end
            end
            hecl_pkg::ST_END: begin
                if (!i_ofull) begin
                    n_state  = hecl_pkg::ST_RUN;
                    cnt_v    = '0;
                    pcnt_v   = '0;
                    n_after  = 1'b1;
                    n_held   = 1'b0;
                    n_bw     = '0;
                    n_halt   = 1'b0;
                    n_final  = 1'b0;
                    n_srem   = 2'd0;
                end
            end
            default: n_state = hecl_pkg::ST_RUN;
        endcase

        // Replay: the '&' goes out as typed and the bytes behind it are fed again
        // ahead of whatever was still waiting.
        if (rep) begin
            em_req  = 1'b1;
            em_n    = 3'd1;
            em_b[0] = hecl_pkg::CH_AMP;
            cv      = int'(cnt_v);
            for (int i = 0; i < W; i++) begin
                kk = i - (cv - 1);
                if (i + 1 < cv) begin
                    n_pend[i] = n_la[i+1];
                end else if (kk >= 0 && kk < W) begin
                    n_pend[i] = pend_v[PIW'(kk)];
                end else begin
                    n_pend[i] = pend_v[i];
                end
            end
            n_pcnt = pcnt_v + cnt_v - CW'(1);
            cnt_v  = '0;
        end else begin
            n_pend = pend_v;
            n_pcnt = pcnt_v;
        end
        n_la_cnt = cnt_v;

        if (sp_req) begin
            if (!r_after && r_bw != '0) begin
                n_held = 1'b1;
            end
            n_after = 1'b1;
        end
        if (big) begin
            n_after = 1'b0;
        end

        if (em_req && !r_halt) begin
            need = em_n + {2'b00, r_held};
            if ({1'b0, r_bw} + (BW + 1)'(need) >= {1'b0, i_budget}) begin
                n_halt = 1'b1;
            end else begin
                for (int i = 0; i < 5; i++) begin
                    if (r_held) begin
                        n_ob[i] = (i == 0) ? hecl_pkg::CH_SPACE : em_b[(i > 0) ? i - 1 : 0];
                    end else begin
                        n_ob[i] = (i < 4) ? em_b[(i < 4) ? i : 0] : 8'h00;
                    end
                end
                n_on    = need;
                n_oi    = 3'd0;
                n_bw    = r_bw + BW'(need);
                n_held  = 1'b0;
                n_after = 1'b0;
                n_state = hecl_pkg::ST_EMIT;
            end
        end
    end

    // Outputs toward the result queue.
    always_comb begin
        o_opush = 1'b0;
        o_obyte = 8'h00;
        o_ohas  = 1'b0;
        o_oend  = 1'b0;
        unique case (r_state)
            hecl_pkg::ST_EMIT: begin
                o_opush = !i_ofull;
                o_obyte = r_ob[r_oi];
                o_ohas  = 1'b1;
            end
            hecl_pkg::ST_END: begin
                o_opush = !i_ofull;
                o_oend  = 1'b1;
            end
            default: o_opush = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hecl_pkg::ST_RUN;
            r_la_cnt <= '0;
            r_pcnt   <= '0;
            r_after  <= 1'b1;
            r_held   <= 1'b0;
            r_halt   <= 1'b0;
            r_final  <= 1'b0;
            r_bw     <= '0;
            r_srem   <= 2'd0;
            r_on     <= 3'd0;
            r_oi     <= 3'd0;
        end else begin
            r_state  <= n_state;
            r_la_cnt <= n_la_cnt;
            r_pcnt   <= n_pcnt;
            r_after  <= n_after;
            r_held   <= n_held;
            r_halt   <= n_halt;
            r_final  <= n_final;
            r_bw     <= n_bw;
            r_srem   <= n_srem;
            r_on     <= n_on;
            r_oi     <= n_oi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_la    <= n_la;
        r_pend  <= n_pend;
        r_seq   <= n_seq;
        r_slen  <= n_slen;
        r_hash  <= n_hash;
        r_hex   <= n_hex;
        r_numok <= n_numok;
        r_ndig  <= n_ndig;
        r_acc   <= n_acc;
        r_ob    <= n_ob;
    end

`ifndef SYNTHESIS
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt < CW'(W))
        else $error("replay queue overflow");
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hecl_pkg::ST_RUN) |-> (r_la_cnt < CW'(W)))
        else $error("entity window not released");
    a_emit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hecl_pkg::ST_EMIT) |-> (r_oi < r_on))
        else $error("emit index past item length");
    a_no_input_in_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_final |-> !o_ipop)
        else $error("input taken while region is closing");
`endif

endmodule
